// ----- rtl/frsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frsc_pkg
// Shared types, codes and helpers of the FIFO-replacement session cache.
// ----------------------------------------------------------------------------
package frsc_pkg;

  localparam int unsigned EntriesDef    = 256;
  localparam int unsigned KeyBytesDef   = 64;
  localparam int unsigned ValueBytesDef = 512;

  localparam logic [1:0] OpStore    = 2'd0;
  localparam logic [1:0] OpRetrieve = 2'd1;
  localparam logic [1:0] OpRemove   = 2'd2;

  typedef enum logic [2:0] {
    StStored   = 3'd0,
    StTooLong  = 3'd1,
    StHit      = 3'd2,
    StMiss     = 3'd3,
    StRemoved  = 3'd4,
    StNotFound = 3'd5
  } status_e;

  typedef struct packed {
    logic    gather;
    logic    flush;
    logic    slot_clr;
    logic    slot_inc;
    logic    word_clr;
    logic    word_inc;
    logic    len_rd;
    logic    len_wr;
    logic    len_zero;
    logic    key_rd;
    logic    copy_rd;
    logic    wp_inc;
    logic    val_rd;
    logic    emit;
    logic    resp;
    status_e status;
    logic    cnt_clr;
  } cmd_t;

  typedef struct packed {
    logic too_long;
    logic copy_zero;
    logic copy_last;
    logic slot_last;
    logic klen_eq;
    logic kwords_zero;
    logic kword_last;
    logic key_eq;
    logic vword_last;
  } sts_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fifo_replacement_session_cache_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_replacement_session_cache_unit
// Key/value cache with FIFO replacement, fed by 64-bit message words.
// ----------------------------------------------------------------------------
// Message words: one per cycle while idle; the last word is followed by a flush.
// Store: after the flush, the staged words are copied one word per cycle
// through the staging read port. Retrieve/remove: check the key length, then
// compare key words, walking slots from zero; a hit then streams one
// value word per cycle. Results appear in the cycle after they are formed and
// the receiver cannot stall. Reset starts a pass that clears the length table.
// ----------------------------------------------------------------------------
module fifo_replacement_session_cache_unit #(
  parameter int unsigned ENTRIES     = frsc_pkg::EntriesDef,
  parameter int unsigned KEY_BYTES   = frsc_pkg::KeyBytesDef,
  parameter int unsigned VALUE_BYTES = frsc_pkg::ValueBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic        section_i,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_i,
  output logic             result_strobe_o,
  output logic [2:0]       status_o,
  output logic [9:0]       value_size_o,
  output logic [63:0]      value_word_o,
  output logic             run_end_o
);

  frsc_pkg::cmd_t cmd;
  frsc_pkg::sts_t sts;

  frsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_i      (last_i),
    .operation_i (operation_i),
    .busy_o      (busy_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  frsc_dp #(
    .ENTRIES     (ENTRIES),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .section_i       (section_i),
    .data_word_i     (data_word_i),
    .byte_count_i    (byte_count_i),
    .result_strobe_o (result_strobe_o),
    .status_o        (status_o),
    .value_size_o    (value_size_o),
    .value_word_o    (value_word_o),
    .run_end_o       (run_end_o)
  );

endmodule
`default_nettype wire

// ----- rtl/frsc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frsc_dp
// Datapath: staging buffers, slot memories, length table, counters, results.
// ----------------------------------------------------------------------------
module frsc_dp #(
  parameter int unsigned ENTRIES     = frsc_pkg::EntriesDef,
  parameter int unsigned KEY_BYTES   = frsc_pkg::KeyBytesDef,
  parameter int unsigned VALUE_BYTES = frsc_pkg::ValueBytesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire frsc_pkg::cmd_t  cmd_i,
  output frsc_pkg::sts_t       sts_o,
  input  wire logic            section_i,
  input  wire logic [63:0]     data_word_i,
  input  wire logic [3:0]      byte_count_i,
  output logic                 result_strobe_o,
  output logic [2:0]           status_o,
  output logic [9:0]           value_size_o,
  output logic [63:0]          value_word_o,
  output logic                 run_end_o
);

  localparam int unsigned CWK  = $clog2(KEY_BYTES + 2);
  localparam int unsigned CWV  = $clog2(VALUE_BYTES + 2);
  localparam int unsigned KW   = (KEY_BYTES + 7) / 8;
  localparam int unsigned VW   = (VALUE_BYTES + 7) / 8;
  localparam int unsigned KWB  = (KW > 1) ? $clog2(KW) : 1;
  localparam int unsigned VWB  = (VW > 1) ? $clog2(VW) : 1;
  localparam int unsigned WB   = (KWB > VWB) ? KWB : VWB;
  localparam int unsigned SB   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CMPW = ((CWV > WB) ? CWV : WB) + 4;
  localparam int unsigned KWD  = 1 << KWB;
  localparam int unsigned VWD  = 1 << VWB;

  logic [CWK-1:0] kcnt_q, kcnt_d;
  logic [CWV-1:0] vcnt_q, vcnt_d;
  logic [63:0]    kpart_q, vpart_q;
  logic [SB-1:0]  slot_q, slot_d, wp_q, wp_d;
  logic [WB-1:0]  word_q, word_d;
  logic           cwr_q;
  logic [WB-1:0]  caddr_q, vaddr_q;

  logic [63:0] kst [KWD];
  logic [63:0] vst [VWD];
  logic [63:0] kmem [ENTRIES * KWD];
  logic [63:0] vmem [ENTRIES * VWD];
  logic [CWK+CWV-1:0] lmem [ENTRIES];

  logic [63:0] kst_rd_q, vst_rd_q, krd_q, vrd_q;
  logic [CWK+CWV-1:0] len_q;
  logic [CWK-1:0] klen;
  logic [CWV-1:0] vlen;

  logic [3:0]   n;
  // key gather
  logic         k_ok, k_we, k_cross;
  logic [CWK-1:0] k_room;
  logic [127:0] k_comb;
  logic [CWK-1:0] k_idx;
  // value gather
  logic         v_ok, v_we, v_cross;
  logic [CWV-1:0] v_room;
  logic [127:0] v_comb;
  logic [CWV-1:0] v_idx;

  logic [CMPW-1:0] kwords, vwords_c, copy_w, vwords_l, vwe_l, wq_x, rem_k, rem_v;
  logic [3:0]      nb_k, nb_v;
  logic [63:0]     kmask, vmask;

  assign klen = len_q[CWK+CWV-1:CWV];
  assign vlen = len_q[CWV-1:0];
  assign n    = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;

  assign k_ok    = kcnt_q <= CWK'(KEY_BYTES);
  assign k_room  = CWK'(KEY_BYTES) - kcnt_q;
  assign k_comb  = {64'b0, kpart_q & frsc_pkg::byte_mask({1'b0, kcnt_q[2:0]})}
                 | ({64'b0, data_word_i} << {kcnt_q[2:0], 3'b000});
  assign k_cross = ({1'b0, kcnt_q[2:0]} + n) >= 4'd8;
  assign k_idx   = kcnt_q >> 3;
  assign k_we    = cmd_i.gather && !section_i && k_ok && (n != 4'd0)
                   && (k_idx < CWK'(KW));

  assign v_ok    = vcnt_q <= CWV'(VALUE_BYTES);
  assign v_room  = CWV'(VALUE_BYTES) - vcnt_q;
  assign v_comb  = {64'b0, vpart_q & frsc_pkg::byte_mask({1'b0, vcnt_q[2:0]})}
                 | ({64'b0, data_word_i} << {vcnt_q[2:0], 3'b000});
  assign v_cross = ({1'b0, vcnt_q[2:0]} + n) >= 4'd8;
  assign v_idx   = vcnt_q >> 3;
  assign v_we    = cmd_i.gather && section_i && v_ok && (n != 4'd0)
                   && (v_idx < CWV'(VW));

  assign kwords   = (CMPW'(kcnt_q) + CMPW'(7)) >> 3;
  assign vwords_c = (CMPW'(vcnt_q) + CMPW'(7)) >> 3;
  assign copy_w   = (kwords > vwords_c) ? kwords : vwords_c;
  assign vwords_l = (CMPW'(vlen) + CMPW'(7)) >> 3;
  assign vwe_l    = (vwords_l == '0) ? CMPW'(1) : vwords_l;
  assign wq_x     = CMPW'(word_q);

  assign rem_k = CMPW'(kcnt_q) - (wq_x << 3);
  assign nb_k  = (rem_k >= CMPW'(8)) ? 4'd8 : rem_k[3:0];
  assign kmask = frsc_pkg::byte_mask(nb_k);
  assign rem_v = CMPW'(vlen) - (CMPW'(vaddr_q) << 3);
  assign nb_v  = (rem_v >= CMPW'(8)) ? 4'd8 : rem_v[3:0];
  assign vmask = frsc_pkg::byte_mask(nb_v);

  always_comb begin
    sts_o.too_long    = !k_ok || !v_ok;
    sts_o.copy_zero   = copy_w == '0;
    sts_o.copy_last   = wq_x == copy_w - CMPW'(1);
    sts_o.slot_last   = slot_q == SB'(ENTRIES - 1);
    sts_o.klen_eq     = klen == kcnt_q;
    sts_o.kwords_zero = kcnt_q == '0;
    sts_o.kword_last  = wq_x == kwords - CMPW'(1);
    sts_o.key_eq      = ((krd_q ^ kst_rd_q) & kmask) == '0;
    sts_o.vword_last  = wq_x == vwe_l - CMPW'(1);
  end

  always_comb begin
    kcnt_d = kcnt_q;
    vcnt_d = vcnt_q;
    if (cmd_i.cnt_clr) begin
      kcnt_d = '0;
      vcnt_d = '0;
    end else if (cmd_i.gather && !section_i && k_ok) begin
      kcnt_d = (CWK'(n) > k_room) ? CWK'(KEY_BYTES + 1) : kcnt_q + CWK'(n);
    end else if (cmd_i.gather && section_i && v_ok) begin
      vcnt_d = (CWV'(n) > v_room) ? CWV'(VALUE_BYTES + 1) : vcnt_q + CWV'(n);
    end
    slot_d = slot_q;
    if (cmd_i.slot_clr) begin
      slot_d = '0;
    end else if (cmd_i.slot_inc) begin
      slot_d = slot_q + SB'(1);
    end
    word_d = word_q;
    if (cmd_i.word_clr) begin
      word_d = '0;
    end else if (cmd_i.word_inc) begin
      word_d = word_q + WB'(1);
    end
    wp_d = wp_q;
    if (cmd_i.wp_inc) begin
      wp_d = (wp_q == SB'(ENTRIES - 1)) ? '0 : wp_q + SB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcnt_q          <= '0;
      vcnt_q          <= '0;
      slot_q          <= '0;
      word_q          <= '0;
      wp_q            <= '0;
      cwr_q           <= 1'b0;
      result_strobe_o <= 1'b0;
    end else begin
      kcnt_q          <= kcnt_d;
      vcnt_q          <= vcnt_d;
      slot_q          <= slot_d;
      word_q          <= word_d;
      wp_q            <= wp_d;
      cwr_q           <= cmd_i.copy_rd;
      result_strobe_o <= cmd_i.resp || cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (k_we) begin
      kpart_q <= k_cross ? k_comb[127:64] : k_comb[63:0];
    end
    if (v_we) begin
      vpart_q <= v_cross ? v_comb[127:64] : v_comb[63:0];
    end
    if (cmd_i.copy_rd) begin
      caddr_q <= word_q;
    end
    if (cmd_i.val_rd) begin
      vaddr_q <= word_q;
    end
    if (cmd_i.resp) begin
      status_o     <= cmd_i.status;
      value_size_o <= '0;
      value_word_o <= '0;
      run_end_o    <= 1'b1;
    end else if (cmd_i.emit) begin
      status_o     <= frsc_pkg::StHit;
      value_size_o <= 10'(vlen);
      value_word_o <= vrd_q & vmask;
      run_end_o    <= CMPW'(vaddr_q) == vwe_l - CMPW'(1);
    end
  end

  // staging buffers
  always_ff @(posedge clk_i) begin
    if (k_we) begin
      kst[k_idx[KWB-1:0]] <= k_comb[63:0];
    end else if (cmd_i.flush && k_ok && (kcnt_q[2:0] != 3'd0) && (k_idx < CWK'(KW))) begin
      kst[k_idx[KWB-1:0]] <= kpart_q;
    end
    if (cmd_i.key_rd || cmd_i.copy_rd) begin
      kst_rd_q <= kst[word_q[KWB-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vst[v_idx[VWB-1:0]] <= v_comb[63:0];
    end else if (cmd_i.flush && v_ok && (vcnt_q[2:0] != 3'd0) && (v_idx < CWV'(VW))) begin
      vst[v_idx[VWB-1:0]] <= vpart_q;
    end
    if (cmd_i.copy_rd) begin
      vst_rd_q <= vst[word_q[VWB-1:0]];
    end
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    if (cwr_q && (CMPW'(caddr_q) < kwords)) begin
      kmem[{wp_q, caddr_q[KWB-1:0]}] <= kst_rd_q;
    end
    if (cmd_i.key_rd) begin
      krd_q <= kmem[{slot_q, word_q[KWB-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cwr_q && (CMPW'(caddr_q) < vwords_c)) begin
      vmem[{wp_q, caddr_q[VWB-1:0]}] <= vst_rd_q;
    end
    if (cmd_i.val_rd) begin
      vrd_q <= vmem[{slot_q, word_q[VWB-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_wr) begin
      lmem[wp_q] <= {kcnt_q, vcnt_q};
    end else if (cmd_i.len_zero) begin
      lmem[slot_q] <= '0;
    end
    if (cmd_i.len_rd) begin
      len_q <= lmem[slot_q];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/frsc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frsc_ctrl
// Controller: gathers messages, then sequences store, search and readout.
// ----------------------------------------------------------------------------
module frsc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           last_i,
  input  wire logic [1:0]     operation_i,
  output logic                busy_o,
  output frsc_pkg::cmd_t      cmd_o,
  input  wire frsc_pkg::sts_t sts_i
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FLUSH = 4'd2;
  localparam logic [3:0] S_COPY  = 4'd3;
  localparam logic [3:0] S_CEND  = 4'd4;
  localparam logic [3:0] S_LRD   = 4'd5;
  localparam logic [3:0] S_LCHK  = 4'd6;
  localparam logic [3:0] S_KRD   = 4'd7;
  localparam logic [3:0] S_KCMP  = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_MATCH = 4'd10;
  localparam logic [3:0] S_VRD   = 4'd11;
  localparam logic [3:0] S_VRUN  = 4'd12;
  localparam logic [3:0] S_VTAIL = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;

  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.status = frsc_pkg::StStored;
    case (state_q)
      S_CLEAR: begin
        cmd_o.len_zero = 1'b1;
        if (sts_i.slot_last) begin
          cmd_o.slot_clr = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      S_IDLE: begin
        cmd_o.gather = start_i;
        if (start_i && last_i) begin
          op_d    = operation_i;
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.flush    = 1'b1;
        cmd_o.word_clr = 1'b1;
        cmd_o.slot_clr = 1'b1;
        case (op_q)
          frsc_pkg::OpStore: begin
            if (sts_i.too_long) begin
              cmd_o.resp    = 1'b1;
              cmd_o.status  = frsc_pkg::StTooLong;
              cmd_o.cnt_clr = 1'b1;
              state_d = S_IDLE;
            end else if (sts_i.copy_zero) begin
              state_d = S_CEND;
            end else begin
              state_d = S_COPY;
            end
          end
          frsc_pkg::OpRetrieve, frsc_pkg::OpRemove: begin
            state_d = S_LRD;
          end
          default: begin
            cmd_o.resp    = 1'b1;
            cmd_o.status  = frsc_pkg::StNotFound;
            cmd_o.cnt_clr = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_COPY: begin
        cmd_o.copy_rd  = 1'b1;
        cmd_o.word_inc = 1'b1;
        if (sts_i.copy_last) begin
          state_d = S_CEND;
        end
      end
      S_CEND: begin
        cmd_o.len_wr  = 1'b1;
        cmd_o.wp_inc  = 1'b1;
        cmd_o.resp    = 1'b1;
        cmd_o.status  = frsc_pkg::StStored;
        cmd_o.cnt_clr = 1'b1;
        state_d = S_IDLE;
      end
      S_LRD: begin
        cmd_o.len_rd = 1'b1;
        state_d = S_LCHK;
      end
      S_LCHK: begin
        if (!sts_i.klen_eq) begin
          state_d = S_NEXT;
        end else if (sts_i.kwords_zero) begin
          state_d = S_MATCH;
        end else begin
          state_d = S_KRD;
        end
      end
      S_KRD: begin
        cmd_o.key_rd = 1'b1;
        state_d = S_KCMP;
      end
      S_KCMP: begin
        if (!sts_i.key_eq) begin
          state_d = S_NEXT;
        end else if (sts_i.kword_last) begin
          state_d = S_MATCH;
        end else begin
          cmd_o.word_inc = 1'b1;
          state_d = S_KRD;
        end
      end
      S_NEXT: begin
        cmd_o.word_clr = 1'b1;
        if (sts_i.slot_last) begin
          cmd_o.resp    = 1'b1;
          cmd_o.status  = (op_q == frsc_pkg::OpRetrieve) ? frsc_pkg::StMiss
                                                          : frsc_pkg::StNotFound;
          cmd_o.cnt_clr = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.slot_inc = 1'b1;
          state_d = S_LRD;
        end
      end
      S_MATCH: begin
        cmd_o.word_clr = 1'b1;
        if (op_q == frsc_pkg::OpRemove) begin
          cmd_o.len_zero = 1'b1;
          cmd_o.resp     = 1'b1;
          cmd_o.status   = frsc_pkg::StRemoved;
          cmd_o.cnt_clr  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_VRD;
        end
      end
      S_VRD: begin
        cmd_o.val_rd   = 1'b1;
        cmd_o.word_inc = 1'b1;
        state_d = sts_i.vword_last ? S_VTAIL : S_VRUN;
      end
      S_VRUN: begin
        cmd_o.val_rd   = 1'b1;
        cmd_o.word_inc = 1'b1;
        cmd_o.emit     = 1'b1;
        if (sts_i.vword_last) begin
          state_d = S_VTAIL;
        end
      end
      S_VTAIL: begin
        cmd_o.emit    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q    <= frsc_pkg::OpStore;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  a_one_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.resp && cmd_o.emit))
    else $error("response and readout in the same cycle");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !sts_i.slot_last) |=> (state_q == S_CLEAR))
    else $error("clearing pass left early");

  a_mismatch_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KCMP && !sts_i.key_eq) |=> (state_q == S_NEXT))
    else $error("key mismatch did not advance the search");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO-replacement session cache. Messages are
// sent word by word with random gaps, or none in burst runs. Each accepted word is run through a
// behavioural copy of the cache, which queues the results it should cause.
// Each strobed result is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NSlots = 256;
  localparam int unsigned KeyCap = 64;
  localparam int unsigned ValCap = 512;
  localparam logic [1:0]  OpUnused = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    frsc_pkg::status_e status;
    logic [9:0]        size;
    logic [63:0]       word;
    logic              run_end;
  } cache_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  operation_i = '0;
  logic        section_i = 1'b0;
  logic [63:0] data_word_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic        result_strobe_o;
  logic [2:0]  status_o;
  logic [9:0]  value_size_o;
  logic [63:0] value_word_o;
  logic        run_end_o;

  fifo_replacement_session_cache_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]    slot_key[NSlots][KeyCap];
  logic [7:0]    slot_val[NSlots][ValCap];
  int unsigned   slot_klen[NSlots];
  int unsigned   slot_vlen[NSlots];
  int unsigned   wr_ptr;
  logic [7:0]    key_buf[KeyCap];
  logic [7:0]    val_buf[ValCap];
  int unsigned   key_cnt;
  int unsigned   val_cnt;
  cache_result_t pending_results[$];
  int unsigned   failures = 0;
  int unsigned   words_sent = 0;
  bit            burst = 1'b0;

  function automatic int find_entry();
    bit same;
    for (int s = 0; s < NSlots; s++) begin
      if (slot_klen[s] == key_cnt) begin
        same = 1'b1;
        for (int i = 0; i < key_cnt; i++) begin
          if (slot_key[s][i] != key_buf[i]) same = 1'b0;
        end
        if (same) return s;
      end
    end
    return -1;
  endfunction

  function automatic void push_single(frsc_pkg::status_e st);
    cache_result_t r;
    r.status = st;
    r.size = '0;
    r.word = '0;
    r.run_end = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void model_word(logic [1:0] op, logic sec, logic [63:0] w,
                                     logic [3:0] bc, logic lst);
    int unsigned   n;
    int            f;
    int unsigned   nw;
    cache_result_t r;
    n = (bc > 8) ? 8 : bc;
    for (int i = 0; i < n; i++) begin
      if (sec == 1'b0) begin
        if (key_cnt < KeyCap) begin
          key_buf[key_cnt] = w[8*i +: 8];
          key_cnt++;
        end else key_cnt = KeyCap + 1;
      end else begin
        if (val_cnt < ValCap) begin
          val_buf[val_cnt] = w[8*i +: 8];
          val_cnt++;
        end else val_cnt = ValCap + 1;
      end
    end
    if (!lst) return;
    case (op)
      frsc_pkg::OpStore: begin
        if (key_cnt > KeyCap || val_cnt > ValCap) begin
          push_single(frsc_pkg::StTooLong);
        end else begin
          for (int i = 0; i < key_cnt; i++) slot_key[wr_ptr][i] = key_buf[i];
          for (int i = 0; i < val_cnt; i++) slot_val[wr_ptr][i] = val_buf[i];
          slot_klen[wr_ptr] = key_cnt;
          slot_vlen[wr_ptr] = val_cnt;
          wr_ptr = (wr_ptr + 1) % NSlots;
          push_single(frsc_pkg::StStored);
        end
      end
      frsc_pkg::OpRetrieve: begin
        f = find_entry();
        if (f < 0) begin
          push_single(frsc_pkg::StMiss);
        end else begin
          nw = (slot_vlen[f] + 7) / 8;
          if (nw == 0) nw = 1;
          for (int k = 0; k < nw; k++) begin
            r.status = frsc_pkg::StHit;
            r.size = 10'(slot_vlen[f]);
            r.word = '0;
            for (int b = 0; b < 8; b++) begin
              if (k * 8 + b < slot_vlen[f]) r.word[8*b +: 8] = slot_val[f][k*8+b];
            end
            r.run_end = (k + 1 == nw);
            pending_results.push_back(r);
          end
        end
      end
      frsc_pkg::OpRemove: begin
        f = find_entry();
        if (f < 0) begin
          push_single(frsc_pkg::StNotFound);
        end else begin
          slot_klen[f] = 0;
          slot_vlen[f] = 0;
          push_single(frsc_pkg::StRemoved);
        end
      end
      default: push_single(frsc_pkg::StNotFound);
    endcase
    key_cnt = 0;
    val_cnt = 0;
  endfunction

  always @(posedge clk_i) begin
    cache_result_t e;
    if (rst_ni && result_strobe_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result, status %0d", status_o);
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (status_o != e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          failures++;
        end
        if (value_size_o != e.size) begin
          $error("value_size: expected %0d, got %0d", e.size, value_size_o);
          failures++;
        end
        if (value_word_o != e.word) begin
          $error("value_word: expected %h, got %h", e.word, value_word_o);
          failures++;
        end
        if (run_end_o != e.run_end) begin
          $error("run_end: expected %0d, got %0d", e.run_end, run_end_o);
          failures++;
        end
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic sec, logic [63:0] w,
                           logic [3:0] bc, logic lst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    operation_i  <= op;
    section_i    <= sec;
    data_word_i  <= w;
    byte_count_i <= bc;
    last_i       <= lst;
    do @(posedge clk_i); while (busy_o);
    model_word(op, sec, w, bc, lst);
    words_sent++;
  endtask

  // split each section into words of random fill; hold op on the final word
  task automatic send_msg(logic [1:0] op, byte_q_t kb, byte_q_t vb, bit val_first);
    logic [63:0] w;
    int          take;
    int          pos;
    logic [3:0]  bc;
    logic [1:0]  wop;
    logic        sec;
    byte_q_t     src;
    logic        lst;
    burst = ($urandom_range(0, 3) == 0);
    for (int part = 0; part < 2; part++) begin
      sec = (part == 0) ? val_first : !val_first;
      src = sec ? vb : kb;
      pos = 0;
      while (pos < src.size() || (part == 1 && pos == 0 && src.size() == 0)) begin
        take = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 8;
        if ($urandom_range(0, 9) == 0) take = 0;
        if (take > src.size() - pos) take = src.size() - pos;
        w = {$urandom, $urandom};
        for (int i = 0; i < take; i++) w[8*i +: 8] = src[pos+i];
        bc = 4'(take);
        if (take == 8 && $urandom_range(0, 3) == 0) bc = 4'($urandom_range(9, 15));
        pos += take;
        lst = (part == 1) && (pos >= src.size());
        if (lst && !sec && vb.size() != 0 && val_first == 1'b0) lst = 1'b0;
        wop = (lst || $urandom_range(0, 2) != 0) ? op : 2'($urandom_range(0, 3));
        send_word(wop, sec, w, bc, lst);
        if (lst) break;
        if (src.size() == 0) break;
      end
    end
  endtask

  function automatic byte_q_t make_key(int id, int len);
    byte_q_t q;
    for (int i = 0; i < len; i++) q.push_back(8'(id * 37 + i * 11 + len));
    return q;
  endfunction

  function automatic byte_q_t rand_bytes(int len);
    byte_q_t q;
    for (int i = 0; i < len; i++) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic test_basic();
    byte_q_t none;
    send_msg(frsc_pkg::OpRetrieve, none, none, 0);
    send_msg(frsc_pkg::OpStore, make_key(1, 2), rand_bytes(3), 0);
    send_msg(frsc_pkg::OpRetrieve, make_key(1, 2), none, 0);
    send_msg(frsc_pkg::OpRemove, make_key(1, 2), none, 0);
    send_msg(frsc_pkg::OpRetrieve, make_key(1, 2), none, 0);
    send_msg(frsc_pkg::OpRemove, make_key(1, 2), none, 0);
    send_msg(OpUnused, make_key(2, 3), none, 0);
    send_word(frsc_pkg::OpStore, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0);
    send_word(frsc_pkg::OpStore, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
    send_word(frsc_pkg::OpStore, 1'b1, 64'h0, 4'd9, 1'b1);
    send_word(frsc_pkg::OpRetrieve, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
  endtask

  task automatic test_overlong();
    byte_q_t none;
    send_msg(frsc_pkg::OpStore, make_key(3, 65), rand_bytes(4), 0);
    send_msg(frsc_pkg::OpRetrieve, make_key(3, 65), none, 0);
    send_msg(frsc_pkg::OpRemove, make_key(3, 67), none, 1);
    send_msg(frsc_pkg::OpStore, make_key(4, 5), rand_bytes(513), 1);
  endtask

  task automatic test_capacity();
    byte_q_t none;
    send_msg(frsc_pkg::OpStore, make_key(5, 64), rand_bytes(512), 1);
    send_msg(frsc_pkg::OpRetrieve, make_key(5, 64), none, 0);
    send_msg(frsc_pkg::OpStore, make_key(6, 8), rand_bytes(8), 0);
    send_msg(frsc_pkg::OpRetrieve, make_key(6, 8), none, 0);
  endtask

  task automatic test_wrap();
    int unsigned n_st;
    n_st = NSlots + 4 - wr_ptr;
    for (int unsigned i = 0; i < n_st; i++) begin
      send_word(frsc_pkg::OpStore, 1'b0, {$urandom, $urandom},
                4'($urandom_range(0, 2)), 1'b1);
    end
    send_msg(frsc_pkg::OpRetrieve, make_key(6, 8), rand_bytes(0), 0);
  endtask

  task automatic test_random();
    int      sel;
    int      klen;
    int      vlen;
    int      id;
    byte_q_t kb;
    int unsigned stop_at;
    stop_at = words_sent + 40;
    while (words_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      klen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 66) : $urandom_range(0, 12);
      id = $urandom_range(0, 7);
      kb = ($urandom_range(0, 7) == 0) ? rand_bytes(klen) : make_key(id, klen);
      vlen = $urandom_range(0, 9) == 0 ? $urandom_range(0, 515) : $urandom_range(0, 24);
      if (sel < 40) begin
        send_msg(frsc_pkg::OpStore, kb, rand_bytes(vlen), $urandom_range(0, 1));
      end else if (sel < 75) begin
        send_msg(frsc_pkg::OpRetrieve, kb, rand_bytes($urandom_range(0, 3)), 0);
      end else if (sel < 95) begin
        send_msg(frsc_pkg::OpRemove, kb, rand_bytes(0), $urandom_range(0, 1));
      end else begin
        send_msg(OpUnused, kb, rand_bytes($urandom_range(0, 9)), 0);
      end
    end
  endtask

  initial begin
    for (int s = 0; s < NSlots; s++) begin
      slot_klen[s] = 0;
      slot_vlen[s] = 0;
    end
    wr_ptr = 0;
    key_cnt = 0;
    val_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic();
    test_overlong();
    test_capacity();
    test_random();
    test_wrap();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
